// ===== rtl/itoa_pkg.sv =====
// Shared types, constants and helpers of the integer to ASCII formatter.
package itoa_pkg;

    localparam int DIGIT_CHARS = 22;
    localparam int DIG_IDX_W   = $clog2(DIGIT_CHARS);
    localparam int VALUE_W     = 64;
    localparam int STEP_W      = $clog2(VALUE_W);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_FLAGS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_CHAR    = 2'd2;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_UPPER_X = 8'h58;
    localparam logic [7:0] CHAR_LOWER_X = 8'h78;
    localparam logic [7:0] CHAR_MINUS   = 8'h2d;
    localparam logic [7:0] CHAR_PLUS    = 8'h2b;
    localparam logic [7:0] FILL_RESET   = 8'h20;

    typedef struct packed {
        logic [VALUE_W-1:0] raw_value;
        logic               is_signed;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } out_word_t;

    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_HEX = 2'd1,
        BASE_OCT = 2'd2
    } base_t;

    typedef struct packed {
        logic  load;
        logic  step;
        base_t base;
    } dig_ctl_t;

    typedef logic [DIGIT_CHARS-1:0][3:0] digit_store_t;

    function automatic logic [7:0] digit_glyph(input logic [3:0] d, input logic upper);
        logic [7:0] letter_base;
        letter_base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
        if (d < 4'd10)
            digit_glyph = CHAR_ZERO + {4'b0, d};
        else
            digit_glyph = letter_base + {4'b0, d} - 8'd10;
    endfunction

endpackage

// ===== rtl/itoa_digit_unit.sv =====
// Digit store: direct hex/octal load, shift-and-add-three for binary to decimal.
module itoa_digit_unit
    import itoa_pkg::*;
(
    input  logic               clk,
    input  dig_ctl_t           ctl,
    input  logic [VALUE_W-1:0] mag,
    output digit_store_t       digits
);

    localparam int OCT_W = 3 * DIGIT_CHARS;

    digit_store_t       digits_reg, digits_next;
    logic [VALUE_W-1:0] shift_reg, shift_next;
    digit_store_t       adj;
    logic [OCT_W-1:0]   oct_vec;

    assign oct_vec = OCT_W'(mag);

    always_comb
    begin
        for (int i = 0; i < DIGIT_CHARS; i++)
        begin
            adj[i] = (digits_reg[i] >= 4'd5) ? digits_reg[i] + 4'd3 : digits_reg[i];
        end
        digits_next = digits_reg;
        shift_next  = shift_reg;
        if (ctl.load)
        begin
            shift_next = mag;
            for (int i = 0; i < DIGIT_CHARS; i++)
            begin
                case (ctl.base)
                    BASE_HEX: digits_next[i] = (i < VALUE_W / 4) ? mag[(4 * i) % VALUE_W +: 4] : 4'd0;
                    BASE_OCT: digits_next[i] = {1'b0, oct_vec[3 * i +: 3]};
                    default:  digits_next[i] = 4'd0;
                endcase
            end
        end
        else if (ctl.step)
        begin
            shift_next = {shift_reg[VALUE_W-2:0], 1'b0};
            digits_next[0] = {adj[0][2:0], shift_reg[VALUE_W-1]};
            for (int i = 1; i < DIGIT_CHARS; i++)
            begin
                digits_next[i] = {adj[i][2:0], adj[i-1][3]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        shift_reg  <= shift_next;
    end

    assign digits = digits_reg;

endmodule

// ===== rtl/integer_to_ascii_formatter.sv =====
// Top level of the integer to ASCII formatter: sequencer, settings and output word register.
// Hex and octal values go from the input word straight to the leading-zero scan of the digit
// store; decimal values first pass through shift-and-add-three. Characters then leave at one per
// cycle unless out_ready stalls, up to MAX_CHARS per value; no new word is taken meanwhile.
// Reset clears the settings to flags 0, width 0 and a space fill, and empties the output register.
module integer_to_ascii_formatter
    import itoa_pkg::*;
#(
    parameter int MAX_CHARS = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_word_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_word_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_CHARS + 1);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_CONV = 10'b0000000010,
        S_SCAN = 10'b0000000100,
        S_LPAD = 10'b0000001000,
        S_SIGN = 10'b0000010000,
        S_PFX0 = 10'b0000100000,
        S_PFX1 = 10'b0001000000,
        S_IPAD = 10'b0010000000,
        S_DIG  = 10'b0100000000,
        S_TPAD = 10'b1000000000
    } state_t;

    state_t               state_reg, state_next;
    logic [6:0]           flags_reg, flags_next;
    logic [6:0]           width_reg, width_next;
    logic [7:0]           fill_reg, fill_next;
    logic                 neg_reg, neg_next;
    logic                 nz_reg, nz_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [DIG_IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]     pad_reg, pad_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic                 out_valid_reg, out_valid_next;
    out_word_t            out_data_reg, out_data_next;

    dig_ctl_t             dig_ctl;
    digit_store_t         digits;
    logic                 showpos, upper, hex_f, oct_f, left_f, internal_f, showbase;
    logic                 showsign, accept, emitting, fire;
    logic [1:0]           pre;
    logic [CNT_W-1:0]     width_sat, len_calc, pad_calc, total_calc, pad_now;
    logic                 has_lpad, has_ipad, has_tpad;
    state_t               after_pfx, after_sign, after_lpad, start_state;
    logic [VALUE_W-1:0]   in_mag;
    logic [7:0]           char_sel;

    itoa_digit_unit u_digits
    (
        .clk    (clk),
        .ctl    (dig_ctl),
        .mag    (in_mag),
        .digits (digits)
    );

    assign showpos    = flags_reg[0];
    assign upper      = flags_reg[1];
    assign hex_f      = flags_reg[2];
    assign oct_f      = !hex_f && flags_reg[3];
    assign left_f     = flags_reg[4];
    assign internal_f = flags_reg[5];
    assign showbase   = flags_reg[6];

    assign showsign = neg_reg || showpos;
    assign pre      = (showbase && hex_f) ? 2'd2 : ((showbase && oct_f && nz_reg) ? 2'd1 : 2'd0);

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign in_mag   = (in_data.is_signed && in_data.raw_value[VALUE_W-1])
                      ? ~in_data.raw_value + VALUE_W'(1) : in_data.raw_value;

    assign width_sat  = (width_reg > 7'(MAX_CHARS)) ? CNT_W'(MAX_CHARS) : CNT_W'(width_reg);
    assign len_calc   = CNT_W'(idx_reg) + CNT_W'(1) + CNT_W'(pre) + CNT_W'(showsign);
    assign pad_calc   = (width_sat > len_calc) ? width_sat - len_calc : '0;
    assign total_calc = (width_sat > len_calc) ? width_sat : len_calc;
    assign pad_now    = (state_reg == S_SCAN) ? pad_calc : pad_reg;

    assign has_lpad = left_f && (pad_now != '0);
    assign has_ipad = !left_f && internal_f && (pad_now != '0);
    assign has_tpad = !left_f && !internal_f && (pad_now != '0);

    assign after_pfx   = has_ipad ? S_IPAD : S_DIG;
    assign after_sign  = (pre != 2'd0) ? S_PFX0 : after_pfx;
    assign after_lpad  = showsign ? S_SIGN : after_sign;
    assign start_state = has_lpad ? S_LPAD : after_lpad;

    assign emitting = (state_reg == S_LPAD) || (state_reg == S_SIGN) || (state_reg == S_PFX0)
                      || (state_reg == S_PFX1) || (state_reg == S_IPAD) || (state_reg == S_DIG)
                      || (state_reg == S_TPAD);
    assign fire     = emitting && (!out_valid_reg || out_ready);

    always_comb
    begin
        case (state_reg)
            S_SIGN:  char_sel = neg_reg ? CHAR_MINUS : CHAR_PLUS;
            S_PFX0:  char_sel = CHAR_ZERO;
            S_PFX1:  char_sel = upper ? CHAR_UPPER_X : CHAR_LOWER_X;
            S_DIG:   char_sel = digit_glyph(digits[idx_reg], upper);
            default: char_sel = fill_reg;
        endcase
    end

    always_comb
    begin
        flags_next     = flags_reg;
        width_next     = width_reg;
        fill_next      = fill_reg;
        state_next     = state_reg;
        neg_next       = neg_reg;
        nz_next        = nz_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        pad_next       = pad_reg;
        rem_next       = rem_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        dig_ctl.load   = 1'b0;
        dig_ctl.step   = 1'b0;
        dig_ctl.base   = hex_f ? BASE_HEX : (oct_f ? BASE_OCT : BASE_DEC);

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_FORMAT_FLAGS: flags_next = cfg_data[6:0];
                CFG_PAD_WIDTH:    width_next = cfg_data[6:0];
                CFG_FILL_CHAR:    fill_next  = cfg_data;
                default:          ;
            endcase
        end

        if (fire)
        begin
            out_valid_next          = 1'b1;
            out_data_next.out_char  = char_sel;
            out_data_next.last_char = (rem_reg == CNT_W'(1));
            rem_next                = rem_reg - CNT_W'(1);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    dig_ctl.load = 1'b1;
                    neg_next     = in_data.is_signed && in_data.raw_value[VALUE_W-1];
                    nz_next      = (in_data.raw_value != '0);
                    step_next    = '0;
                    idx_next     = DIG_IDX_W'(DIGIT_CHARS - 1);
                    state_next   = (hex_f || oct_f) ? S_SCAN : S_CONV;
                end
            end
            S_CONV:
            begin
                dig_ctl.step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(VALUE_W - 1))
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if ((idx_reg != '0) && (digits[idx_reg] == 4'd0))
                begin
                    idx_next = idx_reg - DIG_IDX_W'(1);
                end
                else
                begin
                    pad_next   = pad_calc;
                    rem_next   = total_calc;
                    state_next = start_state;
                end
            end
            S_LPAD:
            begin
                if (fire)
                begin
                    pad_next = pad_reg - CNT_W'(1);
                    if (pad_reg == CNT_W'(1))
                        state_next = after_lpad;
                end
            end
            S_SIGN:
            begin
                if (fire)
                    state_next = after_sign;
            end
            S_PFX0:
            begin
                if (fire)
                    state_next = (pre == 2'd2) ? S_PFX1 : after_pfx;
            end
            S_PFX1:
            begin
                if (fire)
                    state_next = after_pfx;
            end
            S_IPAD:
            begin
                if (fire)
                begin
                    pad_next = pad_reg - CNT_W'(1);
                    if (pad_reg == CNT_W'(1))
                        state_next = S_DIG;
                end
            end
            S_DIG:
            begin
                if (fire)
                begin
                    idx_next = idx_reg - DIG_IDX_W'(1);
                    if (idx_reg == '0)
                        state_next = has_tpad ? S_TPAD : S_IDLE;
                end
            end
            S_TPAD:
            begin
                if (fire)
                begin
                    pad_next = pad_reg - CNT_W'(1);
                    if (pad_reg == CNT_W'(1))
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            flags_reg     <= 7'd0;
            width_reg     <= 7'd0;
            fill_reg      <= FILL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            flags_reg     <= flags_next;
            width_reg     <= width_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        nz_reg       <= nz_next;
        step_reg     <= step_next;
        idx_reg      <= idx_next;
        pad_reg      <= pad_next;
        rem_reg      <= rem_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== test/integer_to_ascii_formatter_tb.sv =====
// Self-checking testbench for the integer to ASCII formatter with a character predictor.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_tb;
    import itoa_pkg::*;

    localparam int MAX_CHARS   = 64;
    localparam int DRAIN_LIMIT = 20000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int FLAG_SHOWPOS  = 0;
    localparam int FLAG_UPPER    = 1;
    localparam int FLAG_HEX      = 2;
    localparam int FLAG_OCT      = 3;
    localparam int FLAG_LEFT     = 4;
    localparam int FLAG_INTERNAL = 5;
    localparam int FLAG_SHOWBASE = 6;

    localparam logic [7:0] F_SHOWPOS  = 8'h01;
    localparam logic [7:0] F_UPPER    = 8'h02;
    localparam logic [7:0] F_HEX      = 8'h04;
    localparam logic [7:0] F_OCT      = 8'h08;
    localparam logic [7:0] F_LEFT     = 8'h10;
    localparam logic [7:0] F_INTERNAL = 8'h20;
    localparam logic [7:0] F_SHOWBASE = 8'h40;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_word_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_word_t             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic [6:0] flags_setting = 7'd0;
    logic [6:0] width_setting = 7'd0;
    logic [7:0] fill_setting  = FILL_RESET;

    out_word_t expected_chars[$];
    out_word_t due_char;
    int        mismatch_count = 0;
    int        send_idle_pct  = 25;
    int        recv_idle_pct  = 71;

    integer_to_ascii_formatter #(.MAX_CHARS(MAX_CHARS)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("%0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Builds the characters one value should produce under the current settings.
    function automatic void format_value(input in_word_t w);
        logic [7:0]  digits[$];
        logic [7:0]  text[$];
        logic [63:0] mag;
        logic [63:0] rest;
        logic [63:0] r;
        logic        neg;
        logic        hex;
        logic        oct;
        logic        upper;
        logic        sign_on;
        int unsigned radix;
        int unsigned prefix_len;
        int unsigned width;
        int unsigned pad;
        int unsigned total;
        hex     = flags_setting[FLAG_HEX];
        oct     = !hex && flags_setting[FLAG_OCT];
        upper   = flags_setting[FLAG_UPPER];
        neg     = w.is_signed && w.raw_value[63];
        mag     = neg ? (~w.raw_value + 64'd1) : w.raw_value;
        sign_on = neg || flags_setting[FLAG_SHOWPOS];
        radix   = hex ? 16 : (oct ? 8 : 10);
        rest    = mag;
        do
        begin
            r = rest % radix;
            if (r < 10)
                digits.push_front(CHAR_ZERO + r[7:0]);
            else
                digits.push_front((upper ? CHAR_UPPER_A : CHAR_LOWER_A) + r[7:0] - 8'd10);
            rest = rest / radix;
        end
        while (rest != 0);
        prefix_len = 0;
        if (flags_setting[FLAG_SHOWBASE] && hex)
            prefix_len = 2;
        else if (flags_setting[FLAG_SHOWBASE] && oct && mag != 0)
            prefix_len = 1;
        total = digits.size() + prefix_len + (sign_on ? 1 : 0);
        width = (width_setting > MAX_CHARS) ? MAX_CHARS : width_setting;
        pad   = (width > total) ? width - total : 0;
        if (flags_setting[FLAG_LEFT])
        begin
            repeat (pad) text.push_back(fill_setting);
            pad = 0;
        end
        if (sign_on)
            text.push_back(neg ? CHAR_MINUS : CHAR_PLUS);
        if (prefix_len == 2)
        begin
            text.push_back(CHAR_ZERO);
            text.push_back(upper ? CHAR_UPPER_X : CHAR_LOWER_X);
        end
        else if (prefix_len == 1)
        begin
            text.push_back(CHAR_ZERO);
        end
        if (flags_setting[FLAG_INTERNAL])
        begin
            repeat (pad) text.push_back(fill_setting);
            pad = 0;
        end
        foreach (digits[i])
            text.push_back(digits[i]);
        repeat (pad) text.push_back(fill_setting);
        foreach (text[i])
            expected_chars.push_back('{out_char: text[i], last_char: (i == text.size() - 1)});
    endfunction

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_chars.size() == 0)
            begin
                report_mismatch($sformatf("character %h with nothing expected",
                                          out_data.out_char));
            end
            else
            begin
                due_char = expected_chars.pop_front();
                if (out_data.out_char !== due_char.out_char)
                    report_mismatch($sformatf("character %h, expected %h",
                                              out_data.out_char, due_char.out_char));
                if (out_data.last_char !== due_char.last_char)
                    report_mismatch($sformatf("last flag %b, expected %b on character %h",
                                              out_data.last_char, due_char.last_char,
                                              due_char.out_char));
            end
        end
        if (rst_n && in_valid && in_ready)
            format_value(in_data);
    end

    task automatic send_value(input logic [63:0] value, input logic sgn);
        in_word_t w;
        w.raw_value = value;
        w.is_signed = sgn;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (expected_chars.size() != 0 && guard < DRAIN_LIMIT);
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_FORMAT_FLAGS: flags_setting = data[6:0];
            CFG_PAD_WIDTH:    width_setting = data[6:0];
            CFG_FILL_CHAR:    fill_setting  = data;
            default:          ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_format(input logic [7:0] flags, input logic [7:0] width,
                              input logic [7:0] fill);
        wait_drained();
        write_setting(CFG_FORMAT_FLAGS, flags);
        write_setting(CFG_PAD_WIDTH, width);
        write_setting(CFG_FILL_CHAR, fill);
    endtask

    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        case ($urandom_range(5))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(20));
            2: v = 64'd1 << $urandom_range(63);
            3: v = {32'hFFFF_FFFF, $urandom};
            4: v = {1'b1, 63'd0} + 64'($urandom_range(2)) - 64'd1;
            default: v = ~64'd0 - 64'($urandom_range(3));
        endcase
        return v;
    endfunction

    task automatic test_reset_format();
        send_value(64'd0, 1'b0);
        send_value(64'd42, 1'b1);
        send_value(-64'sd7, 1'b1);
        send_value(~64'd0, 1'b0);
    endtask

    task automatic test_sign_and_base();
        set_format(F_SHOWPOS, 8'd0, FILL_RESET);
        send_value(64'd5, 1'b0);
        send_value({1'b1, 63'd0}, 1'b1);
        set_format(F_HEX, 8'd0, FILL_RESET);
        send_value(64'hFEDC_BA98_7654_3210, 1'b0);
        set_format(F_HEX | F_UPPER | F_SHOWBASE | F_SHOWPOS, 8'd0, FILL_RESET);
        send_value(64'd0, 1'b0);
        send_value(64'hABCD_EF01_2345_6789, 1'b1);
        set_format(F_OCT | F_SHOWBASE, 8'd0, FILL_RESET);
        send_value(64'd0, 1'b0);
        send_value(~64'd0, 1'b0);
        send_value({1'b1, 63'd0}, 1'b1);
        set_format(F_OCT | F_HEX | F_SHOWBASE, 8'd0, FILL_RESET);
        send_value(64'd255, 1'b0);
    endtask

    task automatic test_padding();
        set_format(F_LEFT, 8'd20, 8'h2A);
        send_value(-64'sd123, 1'b1);
        set_format(F_INTERNAL | F_HEX | F_SHOWBASE, 8'd12, 8'h30);
        send_value(64'h1F, 1'b1);
        set_format(F_LEFT | F_INTERNAL | F_SHOWPOS, 8'd9, 8'h2E);
        send_value(64'd77, 1'b0);
        set_format(8'h00, 8'd64, 8'h00);
        send_value(-64'sd1, 1'b1);
        set_format(F_INTERNAL, 8'h7F, 8'hFF);
        send_value(64'd3, 1'b0);
        set_format(F_LEFT | 8'h80, 8'hC0, 8'h5F);
        send_value(64'd10, 1'b0);
        set_format(F_SHOWPOS | F_OCT | F_SHOWBASE, 8'd3, 8'h23);
        send_value({1'b1, 63'd0}, 1'b1);
    endtask

    task automatic test_spare_index();
        set_format(F_HEX, 8'd6, 8'h2D);
        write_setting(CFG_SPARE, 8'hFF);
        send_value(64'hBEEF, 1'b0);
    endtask

    task automatic test_random_formats();
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 25 : ((phase == 1) ? 71 : 0);
            recv_idle_pct = (phase == 0) ? 71 : ((phase == 1) ? 25 : 0);
            for (int k = 0; k < 7; k++)
            begin
                set_format(8'($urandom_range(255)),
                           ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                    : 8'($urandom_range(30)),
                           8'($urandom_range(255)));
                if ($urandom_range(3) == 0)
                    write_setting(CFG_SPARE, 8'($urandom_range(255)));
                repeat (7) send_value(pick_value(), 1'($urandom_range(1)));
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_format();
        test_sign_and_base();
        test_padding();
        test_spare_index();
        test_random_formats();
        wait_drained();
        repeat (200) @(posedge clk);
        if (expected_chars.size() != 0)
            report_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
